// File: rtl/ivfd_pkg.sv
// Shared types and constants for the IVF container deframer.
// Holds the item, record and queue-entry structs, the phase enum and the code values.
// No dependencies.
`default_nettype none

package ivfd_pkg;

    localparam int FILE_HDR_LEN  = 32;
    localparam int FRAME_HDR_LEN = 12;
    localparam int HDR_IDX_W     = $clog2(FILE_HDR_LEN);

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [31:0] SIGNATURE_RESET = 32'h4649_4B44;
    localparam logic [15:0] HDR_SIZE_OK     = 16'(FILE_HDR_LEN);

    localparam int PADDR_W = 3;

    typedef enum logic [1:0] {
        KIND_FILE    = 2'd0,
        KIND_FRAME   = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_END     = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_VERSION       = 3'd1,
        ST_BAD_SIGNATURE = 3'd2,
        ST_BAD_HDR_SIZE  = 3'd3,
        ST_SHORT_FILE    = 3'd4,
        ST_SHORT_FRAME   = 3'd5,
        ST_SHORT_PAYLOAD = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        PH_FILE    = 2'd0,
        PH_FRAME   = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_SKIP    = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic        frame_end;
        logic [31:0] frame_len;
        logic [63:0] timestamp;
        logic [15:0] width;
        logic [15:0] height;
        logic [31:0] fourcc;
        logic [31:0] timebase_den;
        logic [31:0] tbase_num;
        logic [31:0] frame_count;
        logic [2:0]  status;
    } result_t;

    typedef struct packed {
        logic       has_main;
        result_t    main;
        logic       has_end;
        logic [2:0] end_status;
    } entry_t;

    typedef struct packed {
        logic valid;
        logic full;
    } qstat_t;

endpackage

`default_nettype wire

// File: rtl/ivfd_front.sv
// Front end of the deframer: accepts stream bytes, tracks the container phase and
// builds one queue entry per byte that gives records. Depends on ivfd_pkg.
`default_nettype none

module ivfd_front
    import ivfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    input  wire item_t       item,
    input  wire logic [31:0] signature,
    input  wire qstat_t      qstat,
    output logic             accept,
    output logic             push,
    output entry_t           entry
);

    phase_t                 phase_reg, phase_next;
    logic [HDR_IDX_W-1:0]   count_reg, count_next;
    logic [31:0]            left_reg, left_next;
    logic [7:0]             hdr_reg [FILE_HDR_LEN];
    logic [7:0]             shifted [FILE_HDR_LEN];
    logic [8*FILE_HDR_LEN-1:0] hv;
    logic                   store_en;
    logic [31:0]            left_dec;
    logic [2:0]             hstat;

    assign accept = item_valid && !qstat.full;

    always_comb
    begin
        for (int i = 0; i < FILE_HDR_LEN - 1; i++)
        begin
            shifted[i] = hdr_reg[i + 1];
        end
        shifted[FILE_HDR_LEN - 1] = item.data_byte;
        for (int i = 0; i < FILE_HDR_LEN; i++)
        begin
            hv[8*i +: 8] = shifted[i];
        end
    end

    always_comb
    begin
        if (hv[31:0] != signature)
        begin
            hstat = ST_BAD_SIGNATURE;
        end
        else if (hv[63:48] != HDR_SIZE_OK)
        begin
            hstat = ST_BAD_HDR_SIZE;
        end
        else if (hv[47:32] != 16'd0)
        begin
            hstat = ST_VERSION;
        end
        else
        begin
            hstat = ST_OK;
        end
    end

    assign left_dec = (left_reg != 32'd0) ? left_reg - 32'd1 : 32'd0;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        left_next  = left_reg;
        store_en   = 1'b0;
        entry      = '0;
        case (phase_reg)
            PH_FILE:
            begin
                store_en   = 1'b1;
                count_next = count_reg + 1'b1;
                if (count_reg != HDR_IDX_W'(FILE_HDR_LEN - 1))
                begin
                    if (item.last_byte)
                    begin
                        entry.has_end    = 1'b1;
                        entry.end_status = ST_SHORT_FILE;
                        count_next       = '0;
                    end
                end
                else
                begin
                    entry.has_main          = 1'b1;
                    entry.main.kind         = KIND_FILE;
                    entry.main.fourcc       = hv[95:64];
                    entry.main.width        = hv[111:96];
                    entry.main.height       = hv[127:112];
                    entry.main.timebase_den = hv[159:128];
                    entry.main.tbase_num    = hv[191:160];
                    entry.main.frame_count  = hv[223:192];
                    entry.main.status       = hstat;
                    count_next              = '0;
                    if (item.last_byte)
                    begin
                        entry.has_end    = (hstat == ST_OK) || (hstat == ST_VERSION);
                        entry.end_status = ST_OK;
                    end
                    else if ((hstat == ST_OK) || (hstat == ST_VERSION))
                    begin
                        phase_next = PH_FRAME;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_FRAME:
            begin
                store_en   = 1'b1;
                count_next = count_reg + 1'b1;
                if (count_reg != HDR_IDX_W'(FRAME_HDR_LEN - 1))
                begin
                    if (item.last_byte)
                    begin
                        entry.has_end    = 1'b1;
                        entry.end_status = ST_SHORT_FRAME;
                        phase_next       = PH_FILE;
                        count_next       = '0;
                    end
                end
                else
                begin
                    entry.has_main        = 1'b1;
                    entry.main.kind       = KIND_FRAME;
                    entry.main.frame_len  = hv[191:160];
                    entry.main.timestamp  = hv[255:192];
                    entry.main.frame_end  = (hv[191:160] == 32'd0);
                    count_next            = '0;
                    if (item.last_byte)
                    begin
                        entry.has_end    = 1'b1;
                        entry.end_status = (hv[191:160] == 32'd0) ? ST_OK : ST_SHORT_PAYLOAD;
                        phase_next       = PH_FILE;
                    end
                    else if (hv[191:160] != 32'd0)
                    begin
                        left_next  = hv[191:160];
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                entry.has_main          = 1'b1;
                entry.main.kind         = KIND_PAYLOAD;
                entry.main.payload_byte = item.data_byte;
                entry.main.frame_end    = (left_dec == 32'd0);
                left_next               = left_dec;
                if (item.last_byte)
                begin
                    entry.has_end    = 1'b1;
                    entry.end_status = (left_dec == 32'd0) ? ST_OK : ST_SHORT_PAYLOAD;
                    phase_next       = PH_FILE;
                    count_next       = '0;
                    left_next        = '0;
                end
                else if (left_dec == 32'd0)
                begin
                    phase_next = PH_FRAME;
                    count_next = '0;
                end
            end
            default:
            begin
                if (item.last_byte)
                begin
                    phase_next = PH_FILE;
                    count_next = '0;
                    left_next  = '0;
                end
            end
        endcase
    end

    assign push = accept && (entry.has_main || entry.has_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FILE;
            count_reg <= '0;
            left_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && store_en)
        begin
            for (int i = 0; i < FILE_HDR_LEN; i++)
            begin
                hdr_reg[i] <= shifted[i];
            end
        end
    end

    a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (phase_reg == PH_SKIP) |-> !push)
        else $error("record produced while skipping a failed stream");

    a_payload_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (phase_reg == PH_PAYLOAD) && !item.last_byte && (left_reg == 32'd1)
        |=> (phase_reg == PH_FRAME) && (count_reg == '0))
        else $error("frame end did not return to frame header collection");

endmodule

`default_nettype wire

// File: rtl/ivfd_queue.sv
// Short entry queue between the front and back ends of the deframer.
// Depends on ivfd_pkg.
`default_nettype none

module ivfd_queue
    import ivfd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t wr_entry,
    input  wire logic   pop,
    output entry_t      rd_entry,
    output qstat_t      qstat
);

    entry_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    assign rd_entry    = mem_reg[rd_ptr_reg];
    assign qstat.valid = (cnt_reg != '0);
    assign qstat.full  = (cnt_reg == QCNT_W'(QDEPTH));

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.full |-> !push)
        else $error("entry queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !qstat.valid |-> !pop)
        else $error("entry queue underflow");

endmodule

`default_nettype wire

// File: rtl/ivfd_back.sv
// Back end of the deframer: expands each queue entry into one or two records
// and holds them in the output register. Depends on ivfd_pkg.
`default_nettype none

module ivfd_back
    import ivfd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire entry_t head,
    input  wire qstat_t qstat,
    output logic        pop,
    output logic        result_valid,
    input  wire logic   result_stall,
    output result_t     result
);

    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    sub_reg, sub_next;
    logic    load;
    logic    emit_main;
    result_t end_rec;

    always_comb
    begin
        end_rec        = '0;
        end_rec.kind   = KIND_END;
        end_rec.status = head.end_status;
    end

    assign load      = qstat.valid && (!out_valid_reg || !result_stall);
    assign emit_main = head.has_main && !sub_reg;
    assign pop       = load && !(emit_main && head.has_end);

    always_comb
    begin
        out_next       = out_reg;
        sub_next       = sub_reg;
        out_valid_next = out_valid_reg && result_stall;
        if (load)
        begin
            out_next       = emit_main ? head.main : end_rec;
            sub_next       = emit_main && head.has_end;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sub_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sub_reg       <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_status_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ((out_reg.kind == KIND_FRAME) || (out_reg.kind == KIND_PAYLOAD))
        |-> (out_reg.status == ST_OK))
        else $error("status set on a frame or payload record");

    a_second_half: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> qstat.valid && head.has_main && head.has_end)
        else $error("pending stream end without a matching entry");

endmodule

`default_nettype wire

// File: rtl/ivf_container_deframer.sv
// Top level of the IVF container deframer: configuration registers, front end,
// entry queue and back end. Depends on ivfd_pkg, ivfd_front, ivfd_queue, ivfd_back.
//
//   channel   direction  handshake                 payload
//   item      in         item_valid / item_stall   item_t   (data_byte, last_byte)
//   result    out        result_valid / result_stall result_t (one record)
//   config    in         APB psel/penable/pwrite   signature_word at byte address 0
//
// One byte is taken per clock while the four-entry queue has room; its first record
// passes through the queue and then the output register before it is offered.
// A byte that ends a stream on a complete frame header, on a complete file header that
// passes its checks, or in a payload gives two records; the output register drains one
// record per clock while result_stall is low, so such a byte loads it twice. The entry
// queue parts the two sides: input keeps flowing while a record waits, until it fills.
// Reset is asynchronous, active low; the signature returns to DKIF.
`default_nettype none

module ivf_container_deframer
    import ivfd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire item_t              item,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output result_t                 result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [31:0] sig_reg, sig_next;
    logic        sig_sel;
    qstat_t      qstat;
    entry_t      wr_entry;
    entry_t      head;
    logic        push;
    logic        pop;
    logic        accept;

    assign pready  = 1'b1;
    assign sig_sel = (paddr[PADDR_W-1] == 1'b0);
    assign prdata  = sig_sel ? sig_reg : 32'd0;

    always_comb
    begin
        sig_next = sig_reg;
        if (psel && penable && pwrite && sig_sel)
        begin
            sig_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_reg <= SIGNATURE_RESET;
        end
        else
        begin
            sig_reg <= sig_next;
        end
    end

    assign item_stall = qstat.full;

    ivfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .signature  (sig_reg),
        .qstat      (qstat),
        .accept     (accept),
        .push       (push),
        .entry      (wr_entry)
    );

    ivfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (head),
        .qstat    (qstat)
    );

    ivfd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    a_accept_matches: assert property (@(posedge clk) disable iff (!rst_n)
        accept == (item_valid && !item_stall))
        else $error("front end acceptance disagrees with the item handshake");

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for ivf_container_deframer: streams of IVF bytes, a
// predictor of the parsed records, receiver stalls and signature register writes.
// Depends on ivfd_pkg and the deframer RTL only.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ivfd_pkg::*;

    localparam logic [31:0]        DKIF           = 32'h4649_4B44;
    localparam logic [PADDR_W-1:0] ADDR_SIGNATURE = '0;
    localparam int                 FILE_HDR_BYTES = 32;
    localparam int                 FRAME_HDR_BYTES = 12;
    localparam int                 SETTLE_CYCLES  = 16;
    localparam int                 LONG_HOLD      = 80;
    localparam int                 IDLE_LIMIT     = 2000;
    localparam int                 PHASE_BYTES    = 60;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    localparam int STALL_NONE      = 0;
    localparam int STALL_LIGHT     = 1;
    localparam int STALL_HEAVY     = 2;
    localparam int STALL_ALTERNATE = 3;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_stall;
    item_t               item         = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    result_t             result;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [PADDR_W-1:0]  paddr        = '0;
    logic [31:0]         pwdata       = '0;
    logic [31:0]         prdata;
    logic                pready;

    ivf_container_deframer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    item_t       byte_q[$];
    logic [7:0]  stream_bytes[$];
    result_t     expected_records[$];
    int          items_queued   = 0;
    int          items_accepted = 0;
    int          mismatches     = 0;
    int          idle_cycles    = 0;
    int          hold_asks      = 0;

    // parser state mirror
    phase_t      parse_phase = PH_FILE;
    int          hdr_cnt     = 0;
    logic [7:0]  hdr_bytes[0:31];
    logic [31:0] bytes_left  = '0;
    logic [31:0] sig_word    = DKIF;

    function automatic logic [63:0] hdr_le(input int pos, input int len);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < len; i++)
            v[8*i +: 8] = hdr_bytes[(pos + i) % 32];
        return v;
    endfunction

    task automatic restart_stream();
        parse_phase = PH_FILE;
        hdr_cnt     = 0;
        bytes_left  = '0;
    endtask

    task automatic expect_stream_end(input status_t st);
        result_t rec;
        rec        = '0;
        rec.kind   = KIND_END;
        rec.status = st;
        expected_records.push_back(rec);
    endtask

    task automatic deframe_byte(input item_t it);
        result_t     rec;
        status_t     st;
        logic [31:0] fsize;
        rec = '0;
        case (parse_phase)
            PH_FILE:
            begin
                hdr_bytes[hdr_cnt] = it.data_byte;
                hdr_cnt++;
                if (hdr_cnt < FILE_HDR_BYTES)
                begin
                    if (it.last_byte)
                    begin
                        expect_stream_end(ST_SHORT_FILE);
                        restart_stream();
                    end
                end
                else
                begin
                    rec.kind         = KIND_FILE;
                    rec.fourcc       = 32'(hdr_le(8, 4));
                    rec.width        = 16'(hdr_le(12, 2));
                    rec.height       = 16'(hdr_le(14, 2));
                    rec.timebase_den = 32'(hdr_le(16, 4));
                    rec.tbase_num    = 32'(hdr_le(20, 4));
                    rec.frame_count  = 32'(hdr_le(24, 4));
                    if (hdr_le(0, 4) != {32'h0, sig_word})
                        st = ST_BAD_SIGNATURE;
                    else if (hdr_le(6, 2) != 64'(FILE_HDR_BYTES))
                        st = ST_BAD_HDR_SIZE;
                    else if (hdr_le(4, 2) != 64'h0)
                        st = ST_VERSION;
                    else
                        st = ST_OK;
                    rec.status = st;
                    expected_records.push_back(rec);
                    hdr_cnt = 0;
                    if (it.last_byte)
                    begin
                        if (st == ST_OK || st == ST_VERSION)
                            expect_stream_end(ST_OK);
                        restart_stream();
                    end
                    else
                        parse_phase = (st == ST_OK || st == ST_VERSION) ? PH_FRAME : PH_SKIP;
                end
            end
            PH_FRAME:
            begin
                hdr_bytes[hdr_cnt] = it.data_byte;
                hdr_cnt++;
                if (hdr_cnt < FRAME_HDR_BYTES)
                begin
                    if (it.last_byte)
                    begin
                        expect_stream_end(ST_SHORT_FRAME);
                        restart_stream();
                    end
                end
                else
                begin
                    fsize          = 32'(hdr_le(0, 4));
                    rec.kind       = KIND_FRAME;
                    rec.frame_len  = fsize;
                    rec.timestamp  = hdr_le(4, 8);
                    rec.frame_end  = (fsize == 0);
                    expected_records.push_back(rec);
                    hdr_cnt = 0;
                    if (it.last_byte)
                    begin
                        expect_stream_end((fsize == 0) ? ST_OK : ST_SHORT_PAYLOAD);
                        restart_stream();
                    end
                    else if (fsize != 0)
                    begin
                        bytes_left  = fsize;
                        parse_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                rec.kind         = KIND_PAYLOAD;
                rec.payload_byte = it.data_byte;
                if (bytes_left != 0)
                    bytes_left--;
                rec.frame_end = (bytes_left == 0);
                expected_records.push_back(rec);
                if (it.last_byte)
                begin
                    expect_stream_end((bytes_left == 0) ? ST_OK : ST_SHORT_PAYLOAD);
                    restart_stream();
                end
                else if (bytes_left == 0)
                begin
                    parse_phase = PH_FRAME;
                    hdr_cnt     = 0;
                end
            end
            default:
            begin
                if (it.last_byte)
                    restart_stream();
            end
        endcase
    endtask

    // stream building
    task automatic put_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++)
            stream_bytes.push_back(v[8*i +: 8]);
    endtask

    function automatic logic [31:0] pick_word(input int fill);
        if (fill == FILL_ZERO)
            return 32'h0;
        else if (fill == FILL_ONES)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic put_file_header(input logic [31:0] sig, input logic [15:0] ver,
                                   input logic [15:0] hsize, input int fill);
        put_le(sig, 4);
        put_le(ver, 2);
        put_le(hsize, 2);
        repeat (6) put_le(pick_word(fill), 4);
    endtask

    task automatic put_frame(input logic [31:0] fsize, input logic [63:0] ts, input int n);
        put_le(fsize, 4);
        put_le(ts, 8);
        repeat (n) stream_bytes.push_back(8'($urandom));
    endtask

    task automatic send_stream(input int cut);
        int   len;
        item_t it;
        len = (cut == 0) ? stream_bytes.size() : cut;
        for (int i = 0; i < len; i++)
        begin
            it.data_byte = stream_bytes[i];
            it.last_byte = (i == len - 1);
            byte_q.push_back(it);
            items_queued++;
        end
        stream_bytes.delete();
    endtask

    task automatic random_stream(input logic [31:0] sig);
        int          pick;
        int          nfr;
        logic [31:0] hsig;
        logic [31:0] fsize;
        logic [15:0] ver;
        logic [15:0] hsize;
        pick = $urandom_range(0, 19);
        if (pick < 3)
        begin
            repeat ($urandom_range(1, 40)) stream_bytes.push_back(8'($urandom));
            send_stream(0);
        end
        else
        begin
            hsig  = (pick == 3) ? sig ^ (32'h1 << $urandom_range(0, 31)) : sig;
            hsize = (pick == 4) ? 16'($urandom) : 16'(FILE_HDR_BYTES);
            ver   = (pick == 5 || pick == 6) ? 16'($urandom) : 16'h0;
            put_file_header(hsig, ver, hsize, FILL_RANDOM);
            nfr = $urandom_range(0, 4);
            repeat (nfr)
            begin
                case ($urandom_range(0, 7))
                    0:       fsize = 32'h0;
                    1:       fsize = $urandom_range(17, 48);
                    default: fsize = $urandom_range(1, 8);
                endcase
                put_frame(fsize, {$urandom, $urandom}, fsize);
            end
            if ($urandom_range(0, 5) == 0)
                put_frame($urandom | 32'h100, {$urandom, $urandom}, $urandom_range(0, 6));
            send_stream(($urandom_range(0, 3) == 0) ? $urandom_range(1, stream_bytes.size()) : 0);
        end
    endtask

    task automatic wait_drained();
        while (items_accepted != items_queued || expected_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_signature(input logic [31:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SIGNATURE;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sig_word = v;
    endtask

    // byte sender: bursts with random gaps
    always @(posedge clk)
    begin : sender
        item_t nxt;
        int    burst_left;
        int    gap_left;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                deframe_byte(item);
                items_accepted++;
            end
            if (!item_valid || !item_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (byte_q.size() != 0)
                begin
                    nxt = byte_q.pop_front();
                    item       <= nxt;
                    item_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, with a long hold on request
    always @(posedge clk)
    begin : receiver
        int hold_served;
        int hold_left;
        int pattern_left;
        int stall_mode;
        bit toggle;
        if (rst_n)
        begin
            if (hold_served != hold_asks)
            begin
                hold_served = hold_asks;
                hold_left   = LONG_HOLD;
            end
            if (pattern_left == 0)
            begin
                stall_mode   = $urandom_range(STALL_NONE, STALL_ALTERNATE);
                pattern_left = $urandom_range(8, 64);
            end
            else
                pattern_left--;
            toggle = ~toggle;
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    STALL_LIGHT:     result_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:     result_stall <= ($urandom_range(0, 9) < 7);
                    STALL_ALTERNATE: result_stall <= toggle;
                    default:         result_stall <= 1'b0;
                endcase
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s at %0t: expected %0h, got %0h", name, $time, want, got);
        end
    endtask

    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_records.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected record of kind %0d at %0t", result.kind, $time);
            end
            else
            begin
                want = expected_records.pop_front();
                check_field("kind", want.kind, result.kind);
                check_field("payload_byte", want.payload_byte, result.payload_byte);
                check_field("frame_end", want.frame_end, result.frame_end);
                check_field("frame_len", want.frame_len, result.frame_len);
                check_field("timestamp", want.timestamp, result.timestamp);
                check_field("width", want.width, result.width);
                check_field("height", want.height, result.height);
                check_field("fourcc", want.fourcc, result.fourcc);
                check_field("timebase_den", want.timebase_den, result.timebase_den);
                check_field("tbase_num", want.tbase_num, result.tbase_num);
                check_field("frame_count", want.frame_count, result.frame_count);
                check_field("status", want.status, result.status);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && ((item_valid && !item_stall) || (result_valid && !result_stall)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int          start;
        logic [31:0] sig;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed streams at the reset signature
        stream_bytes.push_back(8'h44);
        send_stream(0);
        put_file_header(DKIF, 16'h0, 16'(FILE_HDR_BYTES), FILL_RANDOM);
        send_stream(FILE_HDR_BYTES - 1);
        put_file_header(DKIF, 16'h0, 16'(FILE_HDR_BYTES), FILL_ZERO);
        send_stream(0);
        put_file_header(DKIF, 16'hFFFF, 16'(FILE_HDR_BYTES), FILL_ONES);
        send_stream(0);
        put_file_header(~DKIF, 16'h0, 16'(FILE_HDR_BYTES), FILL_RANDOM);
        put_frame(32'd2, 64'h0, 2);
        send_stream(0);
        put_file_header(DKIF, 16'h0, 16'hFFFF, FILL_RANDOM);
        send_stream(0);
        put_file_header(DKIF, 16'h0, 16'(FILE_HDR_BYTES), FILL_RANDOM);
        put_frame(32'h0, 64'h0, 0);
        send_stream(FILE_HDR_BYTES + 5);
        put_file_header(DKIF, 16'h0, 16'(FILE_HDR_BYTES), FILL_RANDOM);
        put_frame(32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_stream(0);
        put_file_header(DKIF, 16'h0, 16'(FILE_HDR_BYTES), FILL_RANDOM);
        put_frame(32'd5, {$urandom, $urandom}, 0);
        send_stream(0);
        put_file_header(DKIF, 16'h0, 16'(FILE_HDR_BYTES), FILL_RANDOM);
        put_frame(32'h0, 64'h0, 0);
        put_frame(32'd3, 64'hFFFF_FFFF_FFFF_FFFF, 1);
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'hFF);
        put_frame(32'd1, {$urandom, $urandom}, 1);
        send_stream(0);
        put_file_header(DKIF, 16'h0, 16'(FILE_HDR_BYTES), FILL_ONES);
        put_frame(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 3);
        send_stream(0);
        put_file_header(DKIF, 16'h0, 16'(FILE_HDR_BYTES), FILL_RANDOM);
        put_frame(32'd4, {$urandom, $urandom}, 2);
        send_stream(0);

        for (int p = 1; p <= 4; p++)
        begin
            wait_drained();
            case (p)
                1:       sig = 32'h0;
                2:       sig = 32'hFFFF_FFFF;
                3:       sig = $urandom;
                default: sig = DKIF;
            endcase
            write_signature(sig);
            start = items_queued;
            while (items_queued - start < PHASE_BYTES)
                random_stream(sig);
            if (p % 2 == 0)
                hold_asks++;
        end

        wait_drained();
        if (mismatches == 0 && expected_records.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
